/* design/fgfu_pkg.sv */
package fgfu_pkg;

  localparam int GRID_WIDTH_DEF  = 18;
  localparam int GRID_HEIGHT_DEF = 10;

  localparam int CELL_W   = 7;
  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 16;
  localparam int SUM_W    = 10;
  localparam int ROW_IDX_W = 3;

  // The mean of six cells is taken as (sum * 683) >> 12, exact for sums up to 762.
  localparam int MEAN_RECIP = 683;
  localparam int MEAN_SHIFT = 12;
  localparam int PROD_W     = 20;

  localparam logic [CELL_W-1:0] THRESHOLD_RESET = 7'd8;
  localparam logic [CELL_W-1:0] SEED_HEAT_RESET = 7'd70;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_SEED      = 1'b1
  } reg_idx_e;

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_SEED     = 8'b0000_0100,
    ST_UPD      = 8'b0000_1000,
    ST_DRAIN    = 8'b0001_0000,
    ST_SHOW     = 8'b0010_0000,
    ST_SHOW_END = 8'b0100_0000,
    ST_LOAD     = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic clear;
    logic take;
    logic seed;
    logic walk_init;
    logic walk;
    logic show_init;
    logic show_walk;
    logic load;
    logic show_next;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic walk_last;
    logic show_col_last;
    logic row_last;
    logic out_free;
  } sts_t;

endpackage

/* design/fgfu_ram.sv */
module fgfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

/* design/fgfu_ctrl.sv */
module fgfu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  fgfu_pkg::sts_t  sts_i,
  output fgfu_pkg::cmd_t  cmd_o
);

  fgfu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fgfu_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      fgfu_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = fgfu_pkg::ST_IDLE;
        end
      end
      fgfu_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = fgfu_pkg::ST_SEED;
        end
      end
      fgfu_pkg::ST_SEED: begin
        cmd_o.seed      = 1'b1;
        cmd_o.walk_init = 1'b1;
        state_d         = fgfu_pkg::ST_UPD;
      end
      fgfu_pkg::ST_UPD: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_last) begin
          state_d = fgfu_pkg::ST_DRAIN;
        end
      end
      fgfu_pkg::ST_DRAIN: begin
        // The last cell of the update lands in memory at this edge.
        cmd_o.show_init = 1'b1;
        state_d         = fgfu_pkg::ST_SHOW;
      end
      fgfu_pkg::ST_SHOW: begin
        cmd_o.show_walk = 1'b1;
        if (sts_i.show_col_last) begin
          state_d = fgfu_pkg::ST_SHOW_END;
        end
      end
      fgfu_pkg::ST_SHOW_END: begin
        state_d = fgfu_pkg::ST_LOAD;
      end
      fgfu_pkg::ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          if (sts_i.row_last) begin
            state_d = fgfu_pkg::ST_IDLE;
          end else begin
            cmd_o.show_next = 1'b1;
            state_d         = fgfu_pkg::ST_SHOW;
          end
        end
      end
      default: begin
        state_d = fgfu_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

/* design/fgfu_dp.sv */
module fgfu_dp #(
  parameter int GRID_WIDTH  = fgfu_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = fgfu_pkg::GRID_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fgfu_pkg::cmd_t                 cmd_i,
  output fgfu_pkg::sts_t                 sts_o,
  input  logic [4:0]                     seed_column_i,
  input  logic [fgfu_pkg::CELL_W-1:0]    heat_threshold_i,
  input  logic [fgfu_pkg::CELL_W-1:0]    seed_heat_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fgfu_pkg::ROW_IDX_W-1:0] row_index_o,
  output logic [fgfu_pkg::MAX_COLS-1:0]  row_bits_o,
  output logic                           last_row_o
);

  localparam int DEPTH     = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW        = $clog2(DEPTH);
  localparam int XW        = $clog2(GRID_WIDTH);
  localparam int YW        = $clog2(GRID_HEIGHT);
  localparam int SHOW_ROWS = (GRID_HEIGHT - 2 < fgfu_pkg::MAX_ROWS) ?
                             GRID_HEIGHT - 2 : fgfu_pkg::MAX_ROWS;
  localparam int SHOW_COLS = (GRID_WIDTH - 2 < fgfu_pkg::MAX_COLS) ?
                             GRID_WIDTH - 2 : fgfu_pkg::MAX_COLS;
  localparam int SEED_BASE = (GRID_HEIGHT - 2) * GRID_WIDTH;
  localparam int KW        = $clog2(fgfu_pkg::MAX_COLS);

  localparam int CW = fgfu_pkg::CELL_W;

  logic [AW-1:0] clr_addr_q;
  logic [4:0]    seed_col_q;
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [AW-1:0] base_q;

  logic          arr_v_q;
  logic [XW-1:0] arr_x_q;
  logic [AW-1:0] arr_base_q;
  logic          shw_v_q;
  logic [KW-1:0] shw_k_q;

  logic [CW-1:0] nl_q, tc_q, bl_q, bc_q;
  logic [fgfu_pkg::MAX_COLS-1:0] bits_q;

  logic                           out_valid_q;
  logic [fgfu_pkg::ROW_IDX_W-1:0] row_index_q;
  logic [fgfu_pkg::MAX_COLS-1:0]  row_bits_q;
  logic                           last_row_q;

  logic          we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [CW-1:0] rdata_a, rdata_b;

  logic [fgfu_pkg::SUM_W-1:0]  sum;
  logic [fgfu_pkg::PROD_W-1:0] prod;
  logic [CW-1:0]               mean;
  logic                        arr_write;
  logic                        seed_ok;

  fgfu_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  assign raddr_a = base_q + AW'(x_q);
  assign raddr_b = base_q + AW'(GRID_WIDTH) + AW'(x_q);

  // New value of the cell left of the arriving column: the left neighbor is
  // already this frame's value, the rest are still old.
  assign sum = fgfu_pkg::SUM_W'(nl_q) + fgfu_pkg::SUM_W'(tc_q) + fgfu_pkg::SUM_W'(rdata_a)
             + fgfu_pkg::SUM_W'(bl_q) + fgfu_pkg::SUM_W'(bc_q) + fgfu_pkg::SUM_W'(rdata_b);
  assign prod = fgfu_pkg::PROD_W'(sum) * fgfu_pkg::PROD_W'(fgfu_pkg::MEAN_RECIP);
  assign mean = prod[fgfu_pkg::MEAN_SHIFT +: CW];

  assign arr_write = arr_v_q && (arr_x_q >= XW'(2));
  assign seed_ok   = int'(seed_col_q) < GRID_WIDTH;

  always_comb begin
    we    = 1'b0;
    waddr = arr_base_q + AW'(arr_x_q) - AW'(1);
    wdata = mean;
    if (cmd_i.clear) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = '0;
    end else if (cmd_i.seed) begin
      we    = seed_ok;
      waddr = AW'(SEED_BASE) + AW'(seed_col_q);
      wdata = seed_heat_i;
    end else if (arr_write) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      x_q         <= '0;
      y_q         <= '0;
      base_q      <= '0;
      arr_v_q     <= 1'b0;
      shw_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end

      arr_v_q <= cmd_i.walk;
      shw_v_q <= cmd_i.show_walk;

      if (cmd_i.walk_init || cmd_i.show_init) begin
        x_q    <= cmd_i.show_init ? XW'(1) : '0;
        y_q    <= YW'(1);
        base_q <= AW'(GRID_WIDTH);
      end else if (cmd_i.walk) begin
        if (x_q == XW'(GRID_WIDTH - 1)) begin
          x_q    <= '0;
          y_q    <= y_q + YW'(1);
          base_q <= base_q + AW'(GRID_WIDTH);
        end else begin
          x_q <= x_q + XW'(1);
        end
      end else if (cmd_i.show_walk) begin
        x_q <= x_q + XW'(1);
      end else if (cmd_i.show_next) begin
        x_q    <= XW'(1);
        y_q    <= y_q + YW'(1);
        base_q <= base_q + AW'(GRID_WIDTH);
      end

      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      seed_col_q <= seed_column_i;
    end

    if (cmd_i.walk) begin
      arr_x_q    <= x_q;
      arr_base_q <= base_q;
    end
    if (cmd_i.show_walk) begin
      shw_k_q <= KW'(x_q - XW'(1));
    end

    if (arr_v_q) begin
      nl_q <= arr_write ? mean : tc_q;
      tc_q <= rdata_a;
      bl_q <= bc_q;
      bc_q <= rdata_b;
    end

    if (cmd_i.show_init || cmd_i.show_next) begin
      bits_q <= '0;
    end else if (shw_v_q) begin
      bits_q[shw_k_q] <= rdata_a > heat_threshold_i;
    end

    if (cmd_i.load) begin
      row_index_q <= fgfu_pkg::ROW_IDX_W'(y_q - YW'(1));
      row_bits_q  <= bits_q;
      last_row_q  <= sts_o.row_last;
    end
  end

  assign sts_o.clear_last    = clr_addr_q == AW'(DEPTH - 1);
  assign sts_o.walk_last     = (x_q == XW'(GRID_WIDTH - 1)) && (y_q == YW'(GRID_HEIGHT - 2));
  assign sts_o.show_col_last = x_q == XW'(SHOW_COLS);
  assign sts_o.row_last      = y_q == YW'(SHOW_ROWS);
  assign sts_o.out_free      = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign row_index_o = row_index_q;
  assign row_bits_o  = row_bits_q;
  assign last_row_o  = last_row_q;

endmodule

/* design/flame_grid_frame_update.sv */
// Channel  Direction  Handshake              Payload
// -------  ---------  ---------------------  ----------------------------------
// in       sink       in_valid_i/in_stall_o  seed_column_i
// out      source     out_valid_o/out_stall_i row_index_o, row_bits_o, last_row_o
// cfg      APB slave  psel/penable/pready    paddr, pwdata, prdata
//
// A frame seeds the grid, updates its interior rows and shows the displayed rows
// and columns one row at a time. The update walks one column a cycle through a
// two-read-port grid memory. After reset a clearing pass zeroes the grid while
// in_stall_o stays high. A stalled output beat holds the frame at that row.
module flame_grid_frame_update #(
  parameter int GRID_WIDTH  = fgfu_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = fgfu_pkg::GRID_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [4:0]                     seed_column_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fgfu_pkg::ROW_IDX_W-1:0] row_index_o,
  output logic [fgfu_pkg::MAX_COLS-1:0]  row_bits_o,
  output logic                           last_row_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fgfu_pkg::PADDR_W-1:0]   paddr,
  input  logic [fgfu_pkg::PDATA_W-1:0]   pwdata,
  output logic [fgfu_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [fgfu_pkg::CELL_W-1:0] threshold_q;
  logic [fgfu_pkg::CELL_W-1:0] seed_heat_q;
  logic                        cfg_wr;

  fgfu_pkg::cmd_t cmd;
  fgfu_pkg::sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= fgfu_pkg::THRESHOLD_RESET;
      seed_heat_q <= fgfu_pkg::SEED_HEAT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        fgfu_pkg::REG_THRESHOLD: threshold_q <= pwdata[fgfu_pkg::CELL_W-1:0];
        fgfu_pkg::REG_SEED:      seed_heat_q <= pwdata[fgfu_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      fgfu_pkg::REG_THRESHOLD: prdata = fgfu_pkg::PDATA_W'(threshold_q);
      fgfu_pkg::REG_SEED:      prdata = fgfu_pkg::PDATA_W'(seed_heat_q);
      default:                 prdata = '0;
    endcase
  end

  fgfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fgfu_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .seed_column_i    (seed_column_i),
    .heat_threshold_i (threshold_q),
    .seed_heat_i      (seed_heat_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .row_index_o      (row_index_o),
    .row_bits_o       (row_bits_o),
    .last_row_o       (last_row_o)
  );

endmodule

/* tb/testbench.sv */
module testbench;
  import fgfu_pkg::*;

  localparam int GW = GRID_WIDTH_DEF;
  localparam int GH = GRID_HEIGHT_DEF;
  localparam int MEAN_DIV = 6;
  localparam int FRAME_CYCLES = 300;
  localparam int HOLD_CYCLES = 3000;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] index;
    logic [MAX_COLS-1:0]  bits;
    logic                 last;
  } row_beat_t;

  class flame_scoreboard;
    logic [CELL_W-1:0] heat [GH][GW];
    logic [CELL_W-1:0] threshold;
    logic [CELL_W-1:0] seed_heat;
    row_beat_t         pending_rows[$];
    int                errors;

    function new();
      foreach (heat[y, x]) heat[y][x] = '0;
      threshold = THRESHOLD_RESET;
      seed_heat = SEED_HEAT_RESET;
      errors    = 0;
    endfunction

    // Runs one frame on the private grid copy and queues the rows it shows.
    function void note_frame(logic [4:0] column);
      int unsigned sum;
      int          rows;
      int          cols;
      row_beat_t   beat;
      if (column < GW) heat[GH-2][column] = seed_heat;
      for (int y = 1; y < GH - 1; y++) begin
        for (int x = 1; x < GW - 1; x++) begin
          sum = heat[y][x-1] + heat[y][x] + heat[y][x+1]
              + heat[y+1][x-1] + heat[y+1][x] + heat[y+1][x+1];
          heat[y][x] = CELL_W'(sum / MEAN_DIV);
        end
      end
      rows = (GH - 2 < MAX_ROWS) ? GH - 2 : MAX_ROWS;
      cols = (GW - 2 < MAX_COLS) ? GW - 2 : MAX_COLS;
      for (int y = 0; y < rows; y++) begin
        beat.index = ROW_IDX_W'(y);
        beat.bits  = '0;
        beat.last  = (y == rows - 1);
        for (int x = 0; x < cols; x++) begin
          if (heat[y+1][x+1] > threshold) beat.bits[x] = 1'b1;
        end
        pending_rows.push_back(beat);
      end
    endfunction

    function void check_row(logic [ROW_IDX_W-1:0] index, logic [MAX_COLS-1:0] bits,
                            logic last);
      row_beat_t want;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row beat, expected none, got index %0d bits %h last %0b",
                 $time, index, bits, last);
        errors++;
        return;
      end
      want = pending_rows.pop_front();
      if (index !== want.index) begin
        $display("%0t: row_index expected %0d got %0d", $time, want.index, index);
        errors++;
      end
      if (bits !== want.bits) begin
        $display("%0t: row_bits of row %0d expected %h got %h",
                 $time, want.index, want.bits, bits);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_row of row %0d expected %0b got %0b",
                 $time, want.index, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [4:0]           seed_column_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [ROW_IDX_W-1:0] row_index_o;
  logic [MAX_COLS-1:0]  row_bits_o;
  logic                 last_row_o;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [PADDR_W-1:0]   paddr         = '0;
  logic [PDATA_W-1:0]   pwdata        = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  flame_scoreboard sb = new();
  int send_idle_pct = 38;
  int recv_idle_pct = 81;
  int hold_ask_cnt  = 0;
  int cycle_count   = 0;

  flame_grid_frame_update u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .seed_column_i(seed_column_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_index_o  (row_index_o),
    .row_bits_o   (row_bits_o),
    .last_row_o   (last_row_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_row(row_index_o, row_bits_o, last_row_o);
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_ask_cnt) begin
        hold_seen = hold_ask_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_frame(input logic [4:0] column);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    seed_column_i <= column;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_frame(column);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [CELL_W-1:0] value);
    logic [PDATA_W-1:0] noise;
    noise   = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= {noise[PDATA_W-1:CELL_W], value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_THRESHOLD) sb.threshold = value;
    else sb.seed_heat = value;
  endtask

  task automatic wait_drained();
    while (sb.pending_rows.size() != 0) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CELL_W-1:0] thr, input logic [CELL_W-1:0] heat);
    // Drop valid first so the block does not take the last beat again once it idles.
    in_valid_i <= 1'b0;
    wait_drained();
    reg_write(REG_THRESHOLD, thr);
    reg_write(REG_SEED, heat);
  endtask

  task automatic send_random(input int count);
    logic [4:0] column;
    repeat (count) begin
      // Mostly real columns; now and then one past the grid that seeds nothing.
      if ($urandom_range(9) == 0) column = 5'($urandom_range(31, GW));
      else column = 5'($urandom_range(GW - 1, 0));
      send_frame(column);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values, heat built up at one column, then the borders
    // and columns past the grid.
    repeat (5) send_frame(5'd8);
    send_frame(5'd0);
    send_frame(5'd17);
    send_frame(5'd18);
    send_frame(5'd31);
    send_frame(5'd1);
    send_frame(5'd16);
    send_frame(5'd8);

    configure(7'd0, 7'd127);
    send_frame(5'd8);
    send_frame(5'd8);
    send_frame(5'd1);
    send_frame(5'd16);
    send_frame(5'd31);

    configure(7'd127, 7'd0);
    send_frame(5'd8);
    send_frame(5'd8);
    send_frame(5'd0);

    configure(7'($urandom_range(30)), 7'($urandom_range(127, 60)));
    send_random(100);

    send_idle_pct = 81;
    recv_idle_pct = 38;
    configure(7'($urandom_range(127)), 7'($urandom_range(127)));
    send_random(100);

    // No idling; the long receiver hold-off fills the block so it stalls its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(7'($urandom_range(20)), 7'd127);
    hold_ask_cnt++;
    send_random(90);

    configure(7'($urandom_range(127)), 7'($urandom_range(127)));
    send_random(50);

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (FRAME_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_rows.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* flame_grid_frame_update.f */
design/fgfu_pkg.sv
design/fgfu_ram.sv
design/fgfu_ctrl.sv
design/fgfu_dp.sv
design/flame_grid_frame_update.sv
tb/testbench.sv
